[design/sobel_gradient_xy_core_macros.svh]
// Assertion macros for the Sobel gradient core.
`ifndef SOBEL_GRADIENT_XY_CORE_MACROS_SVH
`define SOBEL_GRADIENT_XY_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SGXY_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SGXY_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sgxy_pkg.sv]
package sgxy_pkg;

    localparam int GRAD_W      = 19;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int ROWS_W      = 13;
    localparam int COLS_W      = 11;
    localparam int ROWS_LIMIT  = 4096;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_ROWS      = 2'd0,
        REG_IMAGE_COLS      = 2'd1,
        REG_FRAMES_IN_BATCH = 2'd2
    } cfg_reg_t;

    // Slot of a result within the up to four results of one pixel.
    typedef enum logic [1:0] {
        SLOT_ABOVE_PREV = 2'd0,
        SLOT_ABOVE_EDGE = 2'd1,
        SLOT_LAST_PREV  = 2'd2,
        SLOT_LAST_EDGE  = 2'd3
    } slot_t;

endpackage

[design/sobel_gradient_xy_core.sv]
// The first result of a pixel passes the stage 1 registers, the stage 2 sequencer and the output
// register; the core takes one pixel per cycle while pixel_stall is low. A pixel with several
// results (up to four at the end of a frame's last row) holds the sequencer, which stalls the input.
// Reset (rst_n, asynchronous, active low) clears counters, window and pipeline valids and
// sets all three configuration bounds to 1 (stored as last index 0); line stores stay undefined until written.
`include "sobel_gradient_xy_core_macros.svh"

module sobel_gradient_xy_core
    import sgxy_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int PIXEL_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    // Pixel channel
    input  logic                    pixel_valid,
    output logic                    pixel_stall,
    input  logic [PIXEL_BITS-1:0]   pixel,

    // Result channel
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic signed [GRAD_W-1:0] grad_x,
    output logic signed [GRAD_W-1:0] grad_y,
    output logic [ROW_W-1:0]        out_row,
    output logic [COL_W-1:0]        out_col,
    output logic                    last_of_run,
    output logic                    frame_done,
    output logic                    batch_done,

    // Configuration write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int CNT_W  = (ADDR_W + 1 > COLS_W) ? ADDR_W + 1 : COLS_W;
    localparam int CALC_W = (PIXEL_BITS + 4 > GRAD_W) ? PIXEL_BITS + 4 : GRAD_W;
    localparam int WORD_W = 2 * PIXEL_BITS;

    // ------------------------------------------------------------------
    // Configuration. Store each bound as its last index, already clamped:
    // zero acts as one, rows saturate at the row limit, columns at MAX_COLS.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]     cols_last_reg;
    logic [ROW_W-1:0]      rows_last_reg;
    logic [CFG_DATA_W-1:0] frames_last_reg;

    logic [CNT_W-1:0]      cols_value;
    logic [ROWS_W-1:0]     rows_value;

    assign cfg_ready  = 1'b1;
    assign cols_value = CNT_W'(cfg_data[COLS_W-1:0]);
    assign rows_value = cfg_data[ROWS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_last_reg   <= '0;
            rows_last_reg   <= '0;
            frames_last_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_ROWS:
                begin
                    if (rows_value == '0)
                        rows_last_reg <= '0;
                    else if (rows_value > ROWS_W'(ROWS_LIMIT))
                        rows_last_reg <= ROW_W'(ROWS_LIMIT - 1);
                    else
                        rows_last_reg <= ROW_W'(rows_value - 1'b1);
                end
                REG_IMAGE_COLS:
                begin
                    if (cols_value == '0)
                        cols_last_reg <= '0;
                    else if (cols_value > CNT_W'(MAX_COLS))
                        cols_last_reg <= ADDR_W'(MAX_COLS - 1);
                    else
                        cols_last_reg <= ADDR_W'(cols_value - 1'b1);
                end
                REG_FRAMES_IN_BATCH:
                begin
                    if (cfg_data == '0)
                        frames_last_reg <= '0;
                    else
                        frames_last_reg <= cfg_data - 1'b1;
                end
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control.
    //   stage 1: accepted pixel, its position and the line store read
    //   stage 2: result sequencer, pops one pending result per cycle while the output register is free
    //   output : result register toward the consumer
    // ------------------------------------------------------------------
    logic       s1_valid_reg;
    logic [3:0] s2_mask_reg;
    logic       result_valid_reg;

    logic       s2_busy;
    logic       out_free;
    logic       pop;
    logic       pop_last;
    logic       s2_load_ok;
    logic       s1_move;
    logic       s1_ready;
    logic       pixel_accept;
    logic [3:0] pop_onehot;

    assign s2_busy      = (s2_mask_reg != '0);
    assign out_free     = !result_valid_reg || !result_stall;
    assign pop          = s2_busy && out_free;
    assign pop_onehot   = s2_mask_reg & (~s2_mask_reg + 4'd1);
    assign pop_last     = ((s2_mask_reg & ~pop_onehot) == '0);
    assign s2_load_ok   = !s2_busy || (pop && pop_last);
    assign s1_move      = s1_valid_reg && s2_load_ok;
    assign s1_ready     = !s1_valid_reg || s2_load_ok;
    assign pixel_stall  = !s1_ready;
    assign pixel_accept = pixel_valid && s1_ready;

    // ------------------------------------------------------------------
    // Raster counters, advanced on every accepted pixel.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]     col_count_reg;
    logic [ROW_W-1:0]      row_count_reg;
    logic [CFG_DATA_W-1:0] frame_count_reg;

    logic row_end;
    logic last_row;
    logic last_frame;

    assign row_end    = (col_count_reg >= cols_last_reg);
    assign last_row   = (row_count_reg >= rows_last_reg);
    assign last_frame = (frame_count_reg >= frames_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg   <= '0;
            row_count_reg   <= '0;
            frame_count_reg <= '0;
        end
        else if (pixel_accept)
        begin
            if (row_end)
            begin
                col_count_reg <= '0;
                if (last_row)
                begin
                    row_count_reg   <= '0;
                    frame_count_reg <= last_frame ? '0 : frame_count_reg + 1'b1;
                end
                else
                begin
                    row_count_reg <= row_count_reg + 1'b1;
                end
            end
            else
            begin
                col_count_reg <= col_count_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers.
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] s1_px_reg;
    logic [ADDR_W-1:0]     s1_col_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic                  s1_row_end_reg;
    logic                  s1_last_row_reg;
    logic                  s1_last_frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            s1_px_reg         <= pixel;
            s1_col_reg        <= col_count_reg;
            s1_row_reg        <= row_count_reg;
            s1_row_end_reg    <= row_end;
            s1_last_row_reg   <= last_row;
            s1_last_frame_reg <= last_frame;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: one word per column, {upper, middle}. Read at accept,
    // write when the pixel leaves stage 1 (upper takes the old middle,
    // middle takes the pixel). Forward the write on a same-column read.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] line_mem [MAX_COLS];
    logic [WORD_W-1:0] line_rd_reg;
    logic [WORD_W-1:0] line_wr_data;

    logic [PIXEL_BITS-1:0] rd_upper;
    logic [PIXEL_BITS-1:0] rd_middle;
    logic [PIXEL_BITS-1:0] new_mid;
    logic [PIXEL_BITS-1:0] new_top;

    assign rd_upper     = line_rd_reg[WORD_W-1:PIXEL_BITS];
    assign rd_middle    = line_rd_reg[PIXEL_BITS-1:0];
    assign line_wr_data = {rd_middle, s1_px_reg};

    always_ff @(posedge clk)
    begin
        if (s1_move)
            line_mem[s1_col_reg] <= line_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            if (s1_move && (s1_col_reg == col_count_reg))
                line_rd_reg <= line_wr_data;
            else
                line_rd_reg <= line_mem[col_count_reg];
        end
    end

    // Clamp the rows above the frame to the nearest row present.
    assign new_mid = (s1_row_reg >= ROW_W'(1)) ? rd_middle : s1_px_reg;
    assign new_top = (s1_row_reg >= ROW_W'(2)) ? rd_upper  : new_mid;

    // ------------------------------------------------------------------
    // 3x3 window, column 0 on the left. The first column of a row fills
    // all three columns (left border replicate), later ones shift left.
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] win_top_reg [3];
    logic [PIXEL_BITS-1:0] win_mid_reg [3];
    logic [PIXEL_BITS-1:0] win_bot_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_top_reg[k] <= '0;
                win_mid_reg[k] <= '0;
                win_bot_reg[k] <= '0;
            end
        end
        else if (s1_move)
        begin
            if (s1_col_reg == '0)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_top_reg[k] <= new_top;
                    win_mid_reg[k] <= new_mid;
                    win_bot_reg[k] <= s1_px_reg;
                end
            end
            else
            begin
                for (int k = 0; k < 2; k++)
                begin
                    win_top_reg[k] <= win_top_reg[k+1];
                    win_mid_reg[k] <= win_mid_reg[k+1];
                    win_bot_reg[k] <= win_bot_reg[k+1];
                end
                win_top_reg[2] <= new_top;
                win_mid_reg[2] <= new_mid;
                win_bot_reg[2] <= s1_px_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: which results this pixel causes, in raster order:
    //   the row above at the previous column, the row above at the right
    //   edge, then the same two for the last row itself (bottom replicate).
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]  s2_row_reg;
    logic [ADDR_W-1:0] s2_col_reg;
    logic              s2_frame_end_reg;
    logic              s2_batch_end_reg;
    logic [3:0]        s1_mask;
    logic              s1_has_above;
    logic              s1_has_prev;

    assign s1_has_above = (s1_row_reg != '0);
    assign s1_has_prev  = (s1_col_reg != '0);

    always_comb
    begin
        s1_mask                  = '0;
        s1_mask[SLOT_ABOVE_PREV] = s1_has_above && s1_has_prev;
        s1_mask[SLOT_ABOVE_EDGE] = s1_has_above && s1_row_end_reg;
        s1_mask[SLOT_LAST_PREV]  = s1_last_row_reg && s1_has_prev;
        s1_mask[SLOT_LAST_EDGE]  = s1_last_row_reg && s1_row_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_mask_reg <= '0;
        else if (s1_move)
            s2_mask_reg <= s1_mask;
        else if (pop)
            s2_mask_reg <= s2_mask_reg & ~pop_onehot;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_row_reg       <= s1_row_reg;
            s2_col_reg       <= s1_col_reg;
            s2_frame_end_reg <= s1_row_end_reg && s1_last_row_reg;
            s2_batch_end_reg <= s1_row_end_reg && s1_last_row_reg && s1_last_frame_reg;
        end
    end

    // ------------------------------------------------------------------
    // Gradients from the window. Both the row-above and the bottom
    // neighbourhoods come from the same window; select by slot.
    // ------------------------------------------------------------------
    function automatic logic signed [CALC_W-1:0] widen(input logic [PIXEL_BITS-1:0] p);
        widen = signed'(CALC_W'(p));
    endfunction

    // (b0 - a0) + 2 * (b1 - a1) + (b2 - a2)
    function automatic logic signed [CALC_W-1:0] sobel_term(
        input logic [PIXEL_BITS-1:0] a0,
        input logic [PIXEL_BITS-1:0] a1,
        input logic [PIXEL_BITS-1:0] a2,
        input logic [PIXEL_BITS-1:0] b0,
        input logic [PIXEL_BITS-1:0] b1,
        input logic [PIXEL_BITS-1:0] b2
    );
        logic signed [CALC_W-1:0] d1;
        d1 = widen(b1) - widen(a1);
        sobel_term = (widen(b0) - widen(a0)) + (d1 <<< 1) + (widen(b2) - widen(a2));
    endfunction

    logic signed [CALC_W-1:0] gx_above;
    logic signed [CALC_W-1:0] gy_above;
    logic signed [CALC_W-1:0] gx_bottom;
    logic signed [CALC_W-1:0] gy_bottom;

    assign gx_above  = sobel_term(win_top_reg[0], win_mid_reg[0], win_bot_reg[0],
                                  win_top_reg[2], win_mid_reg[2], win_bot_reg[2]);
    assign gy_above  = sobel_term(win_top_reg[0], win_top_reg[1], win_top_reg[2],
                                  win_bot_reg[0], win_bot_reg[1], win_bot_reg[2]);
    assign gx_bottom = sobel_term(win_mid_reg[0], win_bot_reg[0], win_bot_reg[0],
                                  win_mid_reg[2], win_bot_reg[2], win_bot_reg[2]);
    assign gy_bottom = sobel_term(win_mid_reg[0], win_mid_reg[1], win_mid_reg[2],
                                  win_bot_reg[0], win_bot_reg[1], win_bot_reg[2]);

    slot_t             pop_slot;
    logic              pop_bottom;
    logic              pop_prev;
    logic [ADDR_W-1:0] pop_col;

    always_comb
    begin
        case (pop_onehot)
            4'b0001: pop_slot = SLOT_ABOVE_PREV;
            4'b0010: pop_slot = SLOT_ABOVE_EDGE;
            4'b0100: pop_slot = SLOT_LAST_PREV;
            4'b1000: pop_slot = SLOT_LAST_EDGE;
            default: pop_slot = SLOT_ABOVE_PREV;
        endcase
    end

    assign pop_bottom = (pop_slot == SLOT_LAST_PREV) || (pop_slot == SLOT_LAST_EDGE);
    assign pop_prev   = (pop_slot == SLOT_ABOVE_PREV) || (pop_slot == SLOT_LAST_PREV);
    assign pop_col    = pop_prev ? s2_col_reg - 1'b1 : s2_col_reg;

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic signed [GRAD_W-1:0] grad_x_reg;
    logic signed [GRAD_W-1:0] grad_y_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic [COL_W-1:0]         out_col_reg;
    logic                     last_of_run_reg;
    logic                     frame_done_reg;
    logic                     batch_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (out_free)
            result_valid_reg <= pop;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            grad_x_reg      <= GRAD_W'(pop_bottom ? gx_bottom : gx_above);
            grad_y_reg      <= GRAD_W'(pop_bottom ? gy_bottom : gy_above);
            out_row_reg     <= pop_bottom ? s2_row_reg : s2_row_reg - 1'b1;
            out_col_reg     <= COL_W'(pop_col);
            last_of_run_reg <= pop_last;
            frame_done_reg  <= pop_last && s2_frame_end_reg;
            batch_done_reg  <= pop_last && s2_batch_end_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign grad_x       = grad_x_reg;
    assign grad_y       = grad_y_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign last_of_run  = last_of_run_reg;
    assign frame_done   = frame_done_reg;
    assign batch_done   = batch_done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SGXY_ASSERT_NOW(a_frame_done_ends_run, result_valid && frame_done, last_of_run, "frame_done without last_of_run")
    `SGXY_ASSERT_NOW(a_batch_done_ends_frame, result_valid && batch_done, frame_done, "batch_done without frame_done")
    `SGXY_ASSERT_NEXT(a_accept_fills_stage1, pixel_accept, s1_valid_reg, "accepted pixel lost before stage 1")
    `SGXY_ASSERT_NEXT(a_sequencer_drains, pop && !pop_last && !s1_move, s2_busy, "result sequencer emptied early")

endmodule

[sim/sobel_gradient_xy_core_tb.sv]
module sobel_gradient_xy_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgxy_pkg::*;

    localparam int MAX_COLS      = 1024;
    localparam int PIX_W         = 16;
    localparam int RESET_CYCLES  = 8;
    // The core holds each pixel in stage 1, then stage 2 and the output register;
    // wait SETTLE_CYCLES before touching the registers, so pixels without results are flushed.
    localparam int SETTLE_CYCLES = 8;
    // Longest legal quiet stretch is the longest random gap or stall plus the settle
    // wait; allow a wide margin before calling the run hung.
    localparam int IDLE_LIMIT    = 1000;
    localparam int RANDOM_ITEMS  = 360;

    // Register index past the end of the register list; the core drops it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [ROW_W-1:0]         out_row;
        logic [COL_W-1:0]         out_col;
        logic                     last_of_run;
        logic                     frame_done;
        logic                     batch_done;
    } grad_result_t;

    // Mirror of the core: line stores, 3x3 window, counters and registers,
    // plus the gradients still owed by the core in arrival order.
    class gradient_ledger;
        logic [ROWS_W-1:0]     rows_reg;
        logic [COLS_W-1:0]     cols_reg;
        logic [CFG_DATA_W-1:0] frames_reg;
        logic [PIX_W-1:0]      upper_mem [MAX_COLS];
        logic [PIX_W-1:0]      middle_mem [MAX_COLS];
        logic [PIX_W-1:0]      win [3][3];     // [column][row], column 0 = left
        int                    col_cnt;
        int                    row_cnt;
        int                    frame_cnt;
        grad_result_t          pending_grads [$];
        int                    errors;

        function new();
            rows_reg   = 1;
            cols_reg   = 1;
            frames_reg = 1;
            col_cnt    = 0;
            row_cnt    = 0;
            frame_cnt  = 0;
            errors     = 0;
            foreach (win[k, j]) win[k][j] = '0;
            foreach (upper_mem[i])
            begin
                upper_mem[i]  = '0;
                middle_mem[i] = '0;
            end
        endfunction

        function int rows_of(logic [ROWS_W-1:0] v);
            if (v == 0) return 1;
            if (v > ROWS_LIMIT) return ROWS_LIMIT;
            return int'(v);
        endfunction

        function int cols_of(logic [COLS_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_COLS) return MAX_COLS;
            return int'(v);
        endfunction

        function int frames_of(logic [CFG_DATA_W-1:0] v);
            return (v == 0) ? 1 : int'(v);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_IMAGE_ROWS:      rows_reg   = data[ROWS_W-1:0];
                REG_IMAGE_COLS:      cols_reg   = data[COLS_W-1:0];
                REG_FRAMES_IN_BATCH: frames_reg = data;
                default: ;
            endcase
        endfunction

        // Bottom mode reads each column as (middle, bottom, bottom): the
        // neighborhood of the last row with the bottom row replicated.
        function grad_result_t window_gradient(bit bottom, int r, int c);
            int           v [3][3];
            int           gx;
            int           gy;
            grad_result_t res;
            for (int k = 0; k < 3; k++)
            begin
                v[k][0] = bottom ? int'(win[k][1]) : int'(win[k][0]);
                v[k][1] = bottom ? int'(win[k][2]) : int'(win[k][1]);
                v[k][2] = int'(win[k][2]);
            end
            gx = (v[2][0] - v[0][0]) + 2 * (v[2][1] - v[0][1]) + (v[2][2] - v[0][2]);
            gy = (v[0][2] - v[0][0]) + 2 * (v[1][2] - v[1][0]) + (v[2][2] - v[2][0]);
            res         = '0;
            res.grad_x  = gx[GRAD_W-1:0];
            res.grad_y  = gy[GRAD_W-1:0];
            res.out_row = r[ROW_W-1:0];
            res.out_col = c[COL_W-1:0];
            return res;
        endfunction

        // Returns 1 when this pixel closes a frame.
        function bit take_pixel(logic [PIX_W-1:0] px);
            int               nr;
            int               nc;
            int               nf;
            int               r;
            int               c;
            int               n;
            logic [PIX_W-1:0] mid;
            logic [PIX_W-1:0] top;
            bit               row_end;
            bit               last_row;
            grad_result_t     run [4];
            nr = rows_of(rows_reg);
            nc = cols_of(cols_reg);
            nf = frames_of(frames_reg);
            r  = row_cnt;
            c  = col_cnt;
            n  = 0;

            mid = (r >= 1) ? middle_mem[c] : px;
            top = (r >= 2) ? upper_mem[c] : mid;
            upper_mem[c]  = middle_mem[c];
            middle_mem[c] = px;

            if (c == 0)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win[k][0] = top;
                    win[k][1] = mid;
                    win[k][2] = px;
                end
            end
            else
            begin
                for (int k = 0; k < 2; k++)
                    for (int j = 0; j < 3; j++)
                        win[k][j] = win[k + 1][j];
                win[2][0] = top;
                win[2][1] = mid;
                win[2][2] = px;
            end

            row_end  = (c >= nc - 1);
            last_row = (r >= nr - 1);

            if (r >= 1)
            begin
                if (c >= 1)
                begin
                    run[n] = window_gradient(1'b0, r - 1, c - 1);
                    n++;
                end
                if (row_end)
                begin
                    run[n] = window_gradient(1'b0, r - 1, c);
                    n++;
                end
            end
            if (last_row)
            begin
                if (c >= 1)
                begin
                    run[n] = window_gradient(1'b1, r, c - 1);
                    n++;
                end
                if (row_end)
                begin
                    run[n] = window_gradient(1'b1, r, c);
                    n++;
                end
            end
            if (n > 0) run[n - 1].last_of_run = 1'b1;

            if (row_end)
            begin
                col_cnt = 0;
                if (last_row)
                begin
                    if (n > 0)
                    begin
                        run[n - 1].frame_done = 1'b1;
                        if (frame_cnt >= nf - 1) run[n - 1].batch_done = 1'b1;
                    end
                    row_cnt   = 0;
                    frame_cnt = (frame_cnt >= nf - 1) ? 0 : frame_cnt + 1;
                end
                else
                begin
                    row_cnt = r + 1;
                end
            end
            else
            begin
                col_cnt = c + 1;
            end

            for (int k = 0; k < n; k++) pending_grads = {pending_grads, run[k]};
            return row_end && last_row;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        task check_field(string name, logic signed [31:0] got, logic signed [31:0] want,
                         grad_result_t owed);
            if (got !== want)
                report($sformatf("pixel (%0d,%0d) %s: got %0d, want %0d",
                                 owed.out_row, owed.out_col, name, got, want));
        endtask

        task match_gradient(grad_result_t got);
            grad_result_t want;
            if (pending_grads.size() == 0)
            begin
                report($sformatf("result for (%0d,%0d) with none outstanding",
                                 got.out_row, got.out_col));
                return;
            end
            want = pending_grads.pop_front();
            check_field("grad_x", 32'($signed(got.grad_x)), 32'($signed(want.grad_x)), want);
            check_field("grad_y", 32'($signed(got.grad_y)), 32'($signed(want.grad_y)), want);
            check_field("out_row", 32'(got.out_row), 32'(want.out_row), want);
            check_field("out_col", 32'(got.out_col), 32'(want.out_col), want);
            check_field("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run), want);
            check_field("frame_done", 32'(got.frame_done), 32'(want.frame_done), want);
            check_field("batch_done", 32'(got.batch_done), 32'(want.batch_done), want);
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     pixel_valid = 1'b0;
    logic                     pixel_stall;
    logic [PIX_W-1:0]         pixel = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [ROW_W-1:0]         out_row;
    logic [COL_W-1:0]         out_col;
    logic                     last_of_run;
    logic                     frame_done;
    logic                     batch_done;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    gradient_ledger   ledger = new();
    bit               sender_quiet = 1'b0;
    logic [PIX_W-1:0] last_px = '0;

    sobel_gradient_xy_core #(
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIX_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .grad_x       (grad_x),
        .grad_y       (grad_y),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_run  (last_of_run),
        .frame_done   (frame_done),
        .batch_done   (batch_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 4 ns clock.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap(bit quiet);
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mix of full-range noise, rail values and slow ramps around the last pixel.
    function automatic logic [PIX_W-1:0] next_pixel();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            last_px = PIX_W'($urandom());
        else if (roll < 55)
            last_px = $urandom_range(0, 1) ? '1 : '0;
        else
            last_px = last_px + PIX_W'($urandom_range(0, 512) - 256);
        return last_px;
    endfunction

    // Write one register; hold valid until the core takes the transaction.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        ledger.write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // Offer one pixel after a random gap; valid stays high after acceptance
    // so the next call can present its pixel on the very next edge.
    task automatic send_pixel(input logic [PIX_W-1:0] px, output bit frame_end);
        int gap;
        gap = pick_gap(sender_quiet);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        do @(posedge clk); while (pixel_stall);
        frame_end = ledger.take_pixel(px);
    endtask

    // Hold off until every owed gradient is back, then let the pipeline
    // flush pixels that owe nothing.
    task automatic drain_results();
        while (ledger.pending_grads.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pick a new geometry and batch size, writing all registers when write_all is set, else a random subset.
    task automatic new_settings(bit write_all);
        logic [CFG_DATA_W-1:0] rows_v;
        logic [CFG_DATA_W-1:0] cols_v;
        logic [CFG_DATA_W-1:0] frames_v;
        int                    roll;

        roll = $urandom_range(0, 99);
        if (roll < 10)      rows_v = '0;
        else if (roll < 16) rows_v = '1;            // clamps to the row limit
        else if (roll < 20) rows_v = CFG_DATA_W'(ROWS_LIMIT);
        else if (roll < 60) rows_v = CFG_DATA_W'($urandom_range(1, 3));
        else                rows_v = CFG_DATA_W'($urandom_range(4, 8));

        roll = $urandom_range(0, 99);
        if (roll < 10)      cols_v = '0;
        else if (roll < 15) cols_v = '1;            // clamps to the line store depth
        else if (roll < 18) cols_v = CFG_DATA_W'(MAX_COLS);
        else if (roll < 55) cols_v = CFG_DATA_W'($urandom_range(1, 3));
        else                cols_v = CFG_DATA_W'($urandom_range(4, 12));

        roll = $urandom_range(0, 99);
        if (roll < 10)      frames_v = '0;
        else if (roll < 15) frames_v = '1;
        else if (roll < 45) frames_v = CFG_DATA_W'(1);
        else                frames_v = CFG_DATA_W'($urandom_range(2, 5));

        // Line stores only hold the columns already seen in this frame: let the
        // width grow only while the frame is still on its first row.
        if (ledger.row_cnt != 0 &&
            ledger.cols_of(cols_v[COLS_W-1:0]) > ledger.cols_of(ledger.cols_reg))
            cols_v = CFG_DATA_W'(ledger.cols_reg);

        if (write_all || $urandom_range(0, 9) < 6) write_cfg(REG_IMAGE_ROWS, rows_v);
        if (write_all || $urandom_range(0, 9) < 6) write_cfg(REG_IMAGE_COLS, cols_v);
        if (write_all || $urandom_range(0, 9) < 6) write_cfg(REG_FRAMES_IN_BATCH, frames_v);
        if ($urandom_range(0, 9) == 0) write_cfg(REG_UNUSED, CFG_DATA_W'($urandom()));
    endtask

    // Result side: check every accepted transaction, then drive the stall
    // for the next edge. Quiet stretches, chosen at random, turn the stalls off.
    initial
    begin : result_side
        int stall_left;
        bit quiet;
        int cyc;
        stall_left = 0;
        quiet      = 1'b0;
        cyc        = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (result_valid && !result_stall)
                    ledger.match_gradient(grad_result_t'{grad_x, grad_y, out_row, out_col,
                                                        last_of_run, frame_done, batch_done});
                cyc++;
                if (cyc % 256 == 0) quiet = ($urandom_range(0, 2) == 0);
                if (stall_left == 0) stall_left = pick_gap(quiet);
                result_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Watchdog: any transaction on any channel restarts the count.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("[%0t] no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("[sobel_gradient_xy_core] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int random_sent;
        int count;
        bit to_frame_end;
        bit frame_end;
        random_sent = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // 3x3 frames, two per batch. A hard vertical edge then a hard
        // horizontal edge drive both gradients to full scale, and the last
        // pixel of each frame owes four results.
        write_cfg(REG_IMAGE_ROWS, 16'd3);
        write_cfg(REG_IMAGE_COLS, 16'd3);
        write_cfg(REG_FRAMES_IN_BATCH, 16'd2);
        write_cfg(REG_UNUSED, '1);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_pixel((c == 0) ? '1 : '0, frame_end);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_pixel((r == 2) ? '1 : '0, frame_end);
        pixel_valid <= 1'b0;
        drain_results();

        // Zero in every register reads as one: single-pixel frames and batches.
        write_cfg(REG_IMAGE_ROWS, '0);
        write_cfg(REG_IMAGE_COLS, '0);
        write_cfg(REG_FRAMES_IN_BATCH, '0);
        send_pixel('1, frame_end);
        send_pixel('0, frame_end);
        pixel_valid <= 1'b0;
        drain_results();

        // Random phases: mostly whole frames, sometimes cut mid-frame so the
        // next settings land on a running frame. Each phase ends with a drain.
        while (random_sent < RANDOM_ITEMS)
        begin
            new_settings(random_sent == 0);
            sender_quiet = ($urandom_range(0, 3) == 0);
            to_frame_end = ($urandom_range(0, 9) < 7);
            count        = to_frame_end ? 60 : $urandom_range(1, 30);
            for (int i = 0; i < count && random_sent < RANDOM_ITEMS; i++)
            begin
                send_pixel(next_pixel(), frame_end);
                random_sent++;
                if (to_frame_end && frame_end) break;
            end
            pixel_valid <= 1'b0;
            drain_results();
        end

        if (ledger.pending_grads.size() != 0)
            ledger.report($sformatf("%0d results never arrived", ledger.pending_grads.size()));
        if (ledger.errors == 0)
            $display("[sobel_gradient_xy_core] OK");
        else
            $display("[sobel_gradient_xy_core] ERROR");
        $finish;
    end

endmodule
